// ===== rtl/core/etp_pkg.sv =====
// shared types, constants and codes for the exclusive-time call stack profiler
package etp_pkg;

  localparam int NUM_FUNCS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 64;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 6;
  localparam int TIME_W   = 32;
  localparam int CHILD_W  = 33;
  localparam int TOTAL_W  = 40;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHILD_W-1:0] CHILD_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_END   = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] evt_time;
    logic              id_ok;
    status_t           status;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_END_SPAN,
    BK_END_CHILD,
    BK_END_TOTAL,
    BK_READ
  } back_state_t;

endpackage

// ===== rtl/core/etp_if.sv =====
// valid/ready channel interfaces for events and results
interface etp_in_if;
  logic                       valid;
  logic                       ready;
  logic [etp_pkg::MODE_W-1:0] mode;
  logic [etp_pkg::ID_W-1:0]   func_id;
  logic [etp_pkg::TIME_W-1:0] event_time;

  modport source (output valid, mode, func_id, event_time, input ready);
  modport sink (input valid, mode, func_id, event_time, output ready);
endinterface

interface etp_out_if;
  logic                         valid;
  logic                         ready;
  logic [etp_pkg::TOTAL_W-1:0]  total_time;
  logic [etp_pkg::STATUS_W-1:0] status;

  modport source (output valid, total_time, status, input ready);
  modport sink (input valid, total_time, status, output ready);
endinterface

// ===== rtl/core/exclusive_time_call_stack_profiler.sv =====
// Exclusive-time call stack profiler. Each function start/end/read event on in_ch gives one
// result on out_ch, in order. The front takes one event per cycle into a two-entry queue while
// it is not full; the back handles a start or rejected event in BK_IDLE, a read in BK_IDLE then
// BK_READ, and an end in BK_IDLE, BK_END_SPAN, BK_END_CHILD and BK_END_TOTAL, set by the single
// read port of the frame and total memories (read frame, read parent child time, update parent,
// update total). A finished result sits in an output register; the back starts no new event
// until it is taken. A clearing pass after reset zeroes the total memory, with in_ch.ready low.
module exclusive_time_call_stack_profiler #(
  parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  etp_in_if.sink    in_ch,
  etp_out_if.source out_ch
);
  import etp_pkg::*;

  bk_stat_t bk_stat;
  cmd_t     fq_cmd, bq_cmd;
  logic     q_push, q_pop, q_full, q_empty;

  etp_front #(
    .NUM_FUNCS   (NUM_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .bk_stat (bk_stat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (fq_cmd)
  );

  etp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (fq_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .cmd_out (bq_cmd)
  );

  etp_back #(
    .NUM_FUNCS   (NUM_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (bq_cmd),
    .q_pop   (q_pop),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/core/etp_queue.sv =====
// short command queue between the front and back parts
module etp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  etp_pkg::cmd_t cmd_in,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output etp_pkg::cmd_t cmd_out
);
  import etp_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/etp_front.sv =====
// front part: accepts events, tracks stack depth and classifies each transaction
module etp_front #(
  parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  etp_in_if.sink            in_ch,
  input  etp_pkg::bk_stat_t bk_stat,
  input  logic              q_full,
  output logic              q_push,
  output etp_pkg::cmd_t     q_cmd
);
  import etp_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt;

  assign in_ch.ready = !q_full && !bk_stat.clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_cmd.op       = OP_NONE;
    q_cmd.id       = in_ch.func_id;
    q_cmd.evt_time = in_ch.event_time;
    q_cmd.id_ok    = (32'(in_ch.func_id) < NUM_FUNCS);
    q_cmd.status   = ST_OK;
    depth_nxt      = depth_r;
    case (in_ch.mode)
      MODE_START: begin
        if (depth_r == DW'(STACK_DEPTH)) begin
          q_cmd.status = ST_OVERFLOW;
        end else begin
          q_cmd.op = OP_PUSH;
          if (q_push) begin
            depth_nxt = depth_r + 1'b1;
          end
        end
      end
      MODE_END: begin
        if (depth_r == '0) begin
          q_cmd.status = ST_EMPTY;
        end else begin
          q_cmd.op = OP_POP;
          if (q_push) begin
            depth_nxt = depth_r - 1'b1;
          end
        end
      end
      MODE_READ: begin
        q_cmd.op = OP_READ;
      end
      default: begin
        q_cmd.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

endmodule

// ===== rtl/core/etp_back.sv =====
// back part: frame and total memories, end-event sequencer and result register
module etp_back #(
  parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  etp_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output etp_pkg::bk_stat_t bk_stat,
  etp_out_if.source         out_ch
);
  import etp_pkg::*;

  localparam int TAW = $clog2(NUM_FUNCS);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);

  logic [TOTAL_W-1:0] tot_mem [NUM_FUNCS];
  logic [TIME_W-1:0]  fs_mem  [STACK_DEPTH];
  logic [CHILD_W-1:0] fc_mem  [STACK_DEPTH];

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r;
  logic [DW-1:0]      sp_r, sp_nxt;
  logic [TAW-1:0]     clr_cnt_r;
  logic [CHILD_W-1:0] span_r, span_nxt;
  logic [CHILD_W-1:0] child_r;
  logic [CHILD_W-1:0] excl_r, excl_nxt;
  logic [TIME_W-1:0]  fs_rd_r;
  logic [CHILD_W-1:0] fc_rd_r;
  logic [TOTAL_W-1:0] tot_rd_r;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;
  status_t            out_status_r;

  logic               out_free, start_ok, has_parent;
  logic [SAW-1:0]     top_idx;
  logic [CHILD_W:0]   child_sum;
  logic [TOTAL_W:0]   total_sum;

  logic               tot_we, tot_re;
  logic [TAW-1:0]     tot_waddr, tot_raddr;
  logic [TOTAL_W-1:0] tot_wdata;
  logic               fs_we, fc_we, fr_re;
  logic [SAW-1:0]     fs_waddr, fc_waddr, fr_raddr;
  logic [CHILD_W-1:0] fc_wdata;
  logic               res_ld;
  logic [TOTAL_W-1:0] res_total;
  status_t            res_status;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign start_ok   = !q_empty && out_free;
  assign top_idx    = SAW'(sp_r - 1'b1);
  assign has_parent = (sp_r != '0);
  assign bk_stat.clearing = (state_r == BK_CLEAR);

  assign span_nxt  = (cmd_r.evt_time >= fs_rd_r)
                   ? ({1'b0, cmd_r.evt_time} - {1'b0, fs_rd_r} + 1'b1) : '0;
  assign excl_nxt  = (span_r > child_r) ? (span_r - child_r) : '0;
  assign child_sum = {1'b0, fc_rd_r} + {1'b0, span_r};
  assign total_sum = {1'b0, tot_rd_r} + (TOTAL_W + 1)'(excl_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == TAW'(NUM_FUNCS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (start_ok) begin
          case (q_cmd.op)
            OP_POP:  state_nxt = BK_END_SPAN;
            OP_READ: state_nxt = BK_READ;
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_END_SPAN:  state_nxt = BK_END_CHILD;
      BK_END_CHILD: state_nxt = BK_END_TOTAL;
      BK_END_TOTAL: state_nxt = BK_IDLE;
      BK_READ:      state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    q_pop      = 1'b0;
    sp_nxt     = sp_r;
    tot_we     = 1'b0;
    tot_waddr  = TAW'(cmd_r.id);
    tot_wdata  = '0;
    tot_re     = 1'b0;
    tot_raddr  = TAW'(q_cmd.id);
    fs_we      = 1'b0;
    fs_waddr   = SAW'(sp_r);
    fc_we      = 1'b0;
    fc_waddr   = SAW'(sp_r);
    fc_wdata   = '0;
    fr_re      = 1'b0;
    fr_raddr   = top_idx;
    res_ld     = 1'b0;
    res_total  = '0;
    res_status = ST_OK;
    case (state_r)
      BK_CLEAR: begin
        tot_we    = 1'b1;
        tot_waddr = clr_cnt_r;
      end
      BK_IDLE: begin
        if (start_ok) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_PUSH: begin
              fs_we  = 1'b1;
              fc_we  = 1'b1;
              sp_nxt = sp_r + 1'b1;
              res_ld = 1'b1;
            end
            OP_POP: begin
              fr_re  = 1'b1;
              tot_re = 1'b1;
              sp_nxt = sp_r - 1'b1;
            end
            OP_READ: begin
              tot_re = 1'b1;
            end
            default: begin
              res_ld     = 1'b1;
              res_status = q_cmd.status;
            end
          endcase
        end
      end
      BK_END_SPAN: begin
        fr_re = has_parent;
      end
      BK_END_CHILD: begin
        fc_we    = has_parent;
        fc_waddr = top_idx;
        fc_wdata = child_sum[CHILD_W] ? CHILD_MAX : child_sum[CHILD_W-1:0];
      end
      BK_END_TOTAL: begin
        tot_we    = cmd_r.id_ok;
        tot_wdata = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        res_ld    = 1'b1;
      end
      BK_READ: begin
        res_ld    = 1'b1;
        res_total = cmd_r.id_ok ? tot_rd_r : '0;
      end
      default: begin
        res_ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      sp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      if (state_r == BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == BK_END_SPAN) begin
      span_r  <= span_nxt;
      child_r <= fc_rd_r;
    end
    if (state_r == BK_END_CHILD) begin
      excl_r <= excl_nxt;
    end
    if (res_ld) begin
      out_total_r  <= res_total;
      out_status_r <= res_status;
    end
  end

  // exclusive totals
  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    if (tot_re) begin
      tot_rd_r <= tot_mem[tot_raddr];
    end
  end

  // frame start times
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= q_cmd.evt_time;
    end
    if (fr_re) begin
      fs_rd_r <= fs_mem[fr_raddr];
    end
  end

  // frame child times
  always_ff @(posedge clk) begin
    if (fc_we) begin
      fc_mem[fc_waddr] <= fc_wdata;
    end
    if (fr_re) begin
      fc_rd_r <= fc_mem[fr_raddr];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.total_time = out_total_r;
  assign out_ch.status     = out_status_r;

endmodule

// ===== rtl/core/etp_checker.sv =====
// port-level checker for the profiler and its bind
module etp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [etp_pkg::TOTAL_W-1:0]  out_total_time,
  input logic [etp_pkg::STATUS_W-1:0] out_status
);
  import etp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_total_time) && $stable(out_status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_total_time == '0)
    else $error("flagged transaction carries a nonzero total");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready && !out_valid)
    else $error("ports active right after reset");

endmodule

bind exclusive_time_call_stack_profiler etp_checker u_etp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_total_time (out_ch.total_time),
  .out_status     (out_ch.status)
);
